[hw/rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside of reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checks that a condition never holds at a rising clock edge outside of reset.
`define ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

[hw/rtl/drs_pkg.sv]
`timescale 1ns / 1ps

package drs_pkg;

   // Port widths of the task id and count fields.
   localparam int ID_W  = 6;
   localparam int CNT_W = 16;

   // Defaults of the top level parameters.
   localparam int MAX_TASKS_DEF  = 64;
   localparam int COUNT_BITS_DEF = 16;

   // A list request emits at most this many results.
   localparam int MAX_RESULTS = 64;
   localparam int RES_W       = $clog2(MAX_RESULTS + 1);

   // Depths of the command queue and the result queue.
   localparam int CMD_DEPTH = 2;
   localparam int RSP_DEPTH = 2;

   typedef enum logic [2:0] {
      ACT_ADD_TASK     = 3'd0,
      ACT_ADD_EDGE     = 3'd1,
      ACT_ADD_AMOUNT   = 3'd2,
      ACT_LIST_READY   = 3'd3,
      ACT_LIST_PARENTS = 3'd4
   } action_type;

   typedef enum logic [1:0] {
      STAT_OK      = 2'd0,
      STAT_FULL    = 2'd1,
      STAT_EMPTY   = 2'd2,
      STAT_INVALID = 2'd3
   } status_type;

   // Command kinds as classified by the front end.
   typedef enum logic [2:0] {
      CMD_ADD_TASK,
      CMD_ADD_EDGE,
      CMD_ADD_AMOUNT,
      CMD_LIST_READY,
      CMD_LIST_PARENTS,
      CMD_FULL,
      CMD_INVALID
   } cmd_kind_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_ADD,
      BK_EDGE,
      BK_AMOUNT,
      BK_REPLY,
      BK_SCAN,
      BK_FINISH
   } back_state_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [ID_W-1:0]   first_task;
      logic [ID_W-1:0]   second_task;
      logic [CNT_W-1:0]  count_value;
      logic              leaf_flag;
   } cmd_type;

   typedef struct packed {
      logic [ID_W-1:0]   task_index;
      logic [CNT_W-1:0]  taken_amount;
      status_type        status;
      logic              last_flag;
   } rsp_type;

endpackage

[hw/rtl/drs_fifo.sv]
`timescale 1ns / 1ps

`include "assert_macros.svh"

module drs_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PTR_W  = $clog2(DEPTH);
   localparam int FILL_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]  slot_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic              do_wr, do_rd;

   assign full    = (fill_ff == FILL_W'(DEPTH));
   assign empty   = (fill_ff == '0);
   assign do_wr   = push && !full;
   assign do_rd   = pop && !empty;
   assign rd_data = slot_ff[rd_ptr_ff];

   // Pointer and fill level update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_wr) begin
         slot_ff[wr_ptr_ff] <= wr_data;
      end
   end

   `ASSERT_CLK(a_fifo_fill_bound, fill_ff <= FILL_W'(DEPTH), "queue fill level above depth")

endmodule

[hw/rtl/drs_front.sv]
`timescale 1ns / 1ps

`include "assert_macros.svh"

module drs_front import drs_pkg::*; #(
   parameter int MAX_TASKS = MAX_TASKS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  logic [2:0]       req_action,
   input  logic [ID_W-1:0]  req_first_task,
   input  logic [ID_W-1:0]  req_second_task,
   input  logic [CNT_W-1:0] req_count_value,
   input  logic             req_leaf_flag,
   output logic             cmd_push,
   output cmd_type          cmd_out,
   input  logic             cmd_full
);

   localparam int TOTAL_W = $clog2(MAX_TASKS + 1);
   localparam int CMP_W   = (ID_W > TOTAL_W) ? ID_W : TOTAL_W;

   logic [TOTAL_W-1:0] total_ff, total_in;
   logic               accept;
   logic               a_bad, b_bad, table_full;

   assign req_full   = cmd_full;
   assign accept     = req_push && !cmd_full;
   assign a_bad      = CMP_W'(req_first_task) >= CMP_W'(total_ff);
   assign b_bad      = CMP_W'(req_second_task) >= CMP_W'(total_ff);
   assign table_full = (total_ff >= TOTAL_W'(MAX_TASKS));

   // Classify the request; the front keeps its own task count so that
   // id checks happen in request order.
   always_comb begin
      cmd_push            = 1'b0;
      total_in            = total_ff;
      cmd_out.kind        = CMD_INVALID;
      cmd_out.first_task  = req_first_task;
      cmd_out.second_task = req_second_task;
      cmd_out.count_value = req_count_value;
      cmd_out.leaf_flag   = req_leaf_flag;
      case (action_type'(req_action))
         ACT_ADD_TASK: begin
            cmd_push = accept;
            if (table_full) begin
               cmd_out.kind = CMD_FULL;
            end else begin
               cmd_out.kind = CMD_ADD_TASK;
               if (accept) begin
                  total_in = total_ff + 1'b1;
               end
            end
         end
         ACT_ADD_EDGE: begin
            cmd_push     = accept;
            cmd_out.kind = (a_bad || b_bad) ? CMD_INVALID : CMD_ADD_EDGE;
         end
         ACT_ADD_AMOUNT: begin
            cmd_push     = accept;
            cmd_out.kind = a_bad ? CMD_INVALID : CMD_ADD_AMOUNT;
         end
         ACT_LIST_READY: begin
            cmd_push     = accept;
            cmd_out.kind = CMD_LIST_READY;
         end
         ACT_LIST_PARENTS: begin
            cmd_push     = accept;
            cmd_out.kind = a_bad ? CMD_INVALID : CMD_LIST_PARENTS;
         end
         default: begin
            // Unused actions are taken and dropped.
            cmd_push = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
      end else begin
         total_ff <= total_in;
      end
   end

   `ASSERT_CLK(a_front_total_bound, total_ff <= TOTAL_W'(MAX_TASKS), "task count above table size")

endmodule

[hw/rtl/drs_back.sv]
`timescale 1ns / 1ps

`include "assert_macros.svh"

module drs_back import drs_pkg::*; #(
   parameter int MAX_TASKS  = MAX_TASKS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_empty,
   output logic    cmd_pop,
   input  cmd_type cmd_head,
   input  logic    rsp_full,
   output logic    rsp_push,
   output rsp_type rsp_out
);

   localparam int TASK_BITS = $clog2(MAX_TASKS);
   localparam int TOTAL_W   = $clog2(MAX_TASKS + 1);
   localparam logic [MAX_TASKS-1:0] ONE_BIT = MAX_TASKS'(1);

   back_state_type state_ff, state_in;
   cmd_type        cur_ff, cur_in;

   logic [TOTAL_W-1:0]   total_ff, total_in;
   logic [MAX_TASKS-1:0] fin_ff, fin_in;
   logic [MAX_TASKS-1:0] leaf_ff, leaf_in;

   // Scan state for the list requests.
   logic [TOTAL_W-1:0]   scan_ff, scan_in;
   logic [TASK_BITS-1:0] ev_idx_ff, ev_idx_in;
   logic                 ev_valid_ff, ev_valid_in;
   logic [TASK_BITS-1:0] pend_ff, pend_in;
   logic                 pend_valid_ff, pend_valid_in;
   logic [RES_W-1:0]     found_ff, found_in;

   // Dependency rows and count pairs.
   logic [MAX_TASKS-1:0]    row_mem [MAX_TASKS];
   logic [MAX_TASKS-1:0]    row_rd_ff;
   logic                    row_re, row_we;
   logic [TASK_BITS-1:0]    row_raddr, row_waddr;
   logic [MAX_TASKS-1:0]    row_wdata;
   logic [2*COUNT_BITS-1:0] cnt_mem [MAX_TASKS];
   logic [2*COUNT_BITS-1:0] cnt_rd_ff;
   logic                    cnt_re, cnt_we;
   logic [TASK_BITS-1:0]    cnt_raddr, cnt_waddr;
   logic [2*COUNT_BITS-1:0] cnt_wdata;

   logic [TASK_BITS-1:0]  head_a, a_idx, b_idx, new_idx;
   logic [COUNT_BITS-1:0] cnt_c, req_c, cur_c, need, take, sum;
   logic                  ready_hit, parent_hit, hit, stall, issue;

   assign head_a  = TASK_BITS'(cmd_head.first_task);
   assign a_idx   = TASK_BITS'(cur_ff.first_task);
   assign b_idx   = TASK_BITS'(cur_ff.second_task);
   assign new_idx = TASK_BITS'(total_ff);

   // Saturating add of an amount.
   assign cnt_c = COUNT_BITS'(cur_ff.count_value);
   assign req_c = cnt_rd_ff[2*COUNT_BITS-1:COUNT_BITS];
   assign cur_c = cnt_rd_ff[COUNT_BITS-1:0];
   assign need  = (req_c > cur_c) ? req_c - cur_c : '0;
   assign take  = (cnt_c < need) ? cnt_c : need;
   assign sum   = cur_c + take;

   // Membership test of the row that is under evaluation.
   assign ready_hit  = !fin_ff[ev_idx_ff] &&
                       (leaf_ff[ev_idx_ff] || ((row_rd_ff & ~fin_ff) == '0));
   assign parent_hit = row_rd_ff[a_idx];
   assign hit        = ev_valid_ff &&
                       ((cur_ff.kind == CMD_LIST_READY) ? ready_hit : parent_hit) &&
                       (found_ff < RES_W'(MAX_RESULTS));
   assign stall      = hit && pend_valid_ff && rsp_full;
   assign issue      = !stall && (scan_ff < total_ff);

   // Sequencer for one command at a time.
   always_comb begin
      state_in      = state_ff;
      cur_in        = cur_ff;
      total_in      = total_ff;
      fin_in        = fin_ff;
      leaf_in       = leaf_ff;
      scan_in       = scan_ff;
      ev_idx_in     = ev_idx_ff;
      ev_valid_in   = ev_valid_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      found_in      = found_ff;
      cmd_pop       = 1'b0;
      rsp_push      = 1'b0;
      rsp_out.task_index   = cur_ff.first_task;
      rsp_out.taken_amount = '0;
      rsp_out.status       = STAT_OK;
      rsp_out.last_flag    = 1'b1;
      row_re    = 1'b0;
      row_raddr = head_a;
      row_we    = 1'b0;
      row_waddr = a_idx;
      row_wdata = '0;
      cnt_re    = 1'b0;
      cnt_raddr = head_a;
      cnt_we    = 1'b0;
      cnt_waddr = a_idx;
      cnt_wdata = '0;
      case (state_ff)
         BK_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop = 1'b1;
               cur_in  = cmd_head;
               case (cmd_head.kind)
                  CMD_ADD_TASK: begin
                     state_in = BK_ADD;
                  end
                  CMD_ADD_EDGE: begin
                     row_re   = 1'b1;
                     state_in = BK_EDGE;
                  end
                  CMD_ADD_AMOUNT: begin
                     cnt_re   = 1'b1;
                     state_in = BK_AMOUNT;
                  end
                  CMD_LIST_READY, CMD_LIST_PARENTS: begin
                     scan_in       = '0;
                     ev_valid_in   = 1'b0;
                     pend_valid_in = 1'b0;
                     found_in      = '0;
                     state_in      = (total_ff == '0) ? BK_FINISH : BK_SCAN;
                  end
                  default: begin
                     state_in = BK_REPLY;
                  end
               endcase
            end
         end
         BK_ADD: begin
            if (!rsp_full) begin
               rsp_push           = 1'b1;
               rsp_out.task_index = ID_W'(total_ff);
               row_we             = 1'b1;
               row_waddr          = new_idx;
               row_wdata          = '0;
               cnt_we             = 1'b1;
               cnt_waddr          = new_idx;
               cnt_wdata          = {cnt_c, {COUNT_BITS{1'b0}}};
               fin_in[new_idx]    = (cnt_c == '0);
               leaf_in[new_idx]   = cur_ff.leaf_flag;
               total_in           = total_ff + 1'b1;
               state_in           = BK_IDLE;
            end
         end
         BK_EDGE: begin
            if (!rsp_full) begin
               rsp_push  = 1'b1;
               row_we    = 1'b1;
               row_wdata = row_rd_ff | (ONE_BIT << b_idx);
               state_in  = BK_IDLE;
            end
         end
         BK_AMOUNT: begin
            if (!rsp_full) begin
               rsp_push             = 1'b1;
               rsp_out.taken_amount = CNT_W'(take);
               cnt_we               = 1'b1;
               cnt_wdata            = {req_c, sum};
               fin_in[a_idx]        = (sum >= req_c);
               state_in             = BK_IDLE;
            end
         end
         BK_REPLY: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               if (cur_ff.kind == CMD_FULL) begin
                  rsp_out.task_index = '0;
                  rsp_out.status     = STAT_FULL;
               end else begin
                  rsp_out.status = STAT_INVALID;
               end
               state_in = BK_IDLE;
            end
         end
         BK_SCAN: begin
            // A member is held back one step so that the final one can carry
            // the last flag.
            if (hit && pend_valid_ff && !rsp_full) begin
               rsp_push           = 1'b1;
               rsp_out.task_index = ID_W'(pend_ff);
               rsp_out.last_flag  = 1'b0;
            end
            if (!stall) begin
               if (hit) begin
                  pend_in       = ev_idx_ff;
                  pend_valid_in = 1'b1;
                  found_in      = found_ff + 1'b1;
               end
               ev_valid_in = issue;
               ev_idx_in   = TASK_BITS'(scan_ff);
               if (issue) begin
                  row_re    = 1'b1;
                  row_raddr = TASK_BITS'(scan_ff);
                  scan_in   = scan_ff + 1'b1;
               end else begin
                  state_in = BK_FINISH;
               end
            end
         end
         BK_FINISH: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               if (pend_valid_ff) begin
                  rsp_out.task_index = ID_W'(pend_ff);
               end else begin
                  rsp_out.task_index = '0;
                  rsp_out.status     = STAT_EMPTY;
               end
               state_in = BK_IDLE;
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BK_IDLE;
         total_ff      <= '0;
         fin_ff        <= '0;
         leaf_ff       <= '0;
         ev_valid_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         found_ff      <= '0;
         scan_ff       <= '0;
      end else begin
         state_ff      <= state_in;
         total_ff      <= total_in;
         fin_ff        <= fin_in;
         leaf_ff       <= leaf_in;
         ev_valid_ff   <= ev_valid_in;
         pend_valid_ff <= pend_valid_in;
         found_ff      <= found_in;
         scan_ff       <= scan_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      ev_idx_ff <= ev_idx_in;
      pend_ff   <= pend_in;
   end

   // Dependency row memory, one port each way, registered read.
   always_ff @(posedge clock) begin
      if (row_we) begin
         row_mem[row_waddr] <= row_wdata;
      end
      if (row_re) begin
         row_rd_ff <= row_mem[row_raddr];
      end
   end

   // Count memory holding the required and current counts of each task.
   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_waddr] <= cnt_wdata;
      end
      if (cnt_re) begin
         cnt_rd_ff <= cnt_mem[cnt_raddr];
      end
   end

   `ASSERT_NEVER(a_back_push_full, rsp_push && rsp_full, "result pushed into a full queue")
   `ASSERT_CLK(a_back_scan_not_last, (state_ff == BK_SCAN) && rsp_push |-> !rsp_out.last_flag,
               "last result sent before the scan ended")
   `ASSERT_CLK(a_back_pop_runs, cmd_pop |=> (state_ff != BK_IDLE), "popped command was not executed")

endmodule

[hw/rtl/dependency_ready_scoreboard.sv]
`timescale 1ns / 1ps

// Task table with a parent-to-child dependency matrix.
// Requests enter through req_push / req_full and carry one action: add a
// task, add an edge, add an amount, list ready tasks or list a task's parents.
// Results leave through rsp_empty / rsp_pop; the oldest waiting result is on
// the rsp_ ports while rsp_empty is low. A list gives one result per member in
// ascending order, the final one marked by rsp_last_flag, or a single result
// with the empty status when there are none.
// A classifying front end checks ids against its own task count and feeds a
// two-entry command queue; the back end executes one command at a time.
// A single-result action is popped in the idle state and pushes its result
// from its own action state. A list on a non-empty table scans it with one
// read of the dependency row memory per cycle while no held-back result
// waits on a full result queue.
// Reset clears the task count and the control state; the table memories
// need no clearing pass since only entries below the count are read.
// When the receiver stalls, results back up into a two-entry result queue,
// the back end waits, and req_full rises once the command queue fills.

module dependency_ready_scoreboard import drs_pkg::*; #(
   parameter int MAX_TASKS  = MAX_TASKS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  logic [2:0]       req_action,
   input  logic [ID_W-1:0]  req_first_task,
   input  logic [ID_W-1:0]  req_second_task,
   input  logic [CNT_W-1:0] req_count_value,
   input  logic             req_leaf_flag,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output logic [ID_W-1:0]  rsp_task_index,
   output logic [CNT_W-1:0] rsp_taken_amount,
   output logic [1:0]       rsp_status,
   output logic             rsp_last_flag
);

   localparam int CMD_W = $bits(cmd_type);
   localparam int RSP_W = $bits(rsp_type);

   cmd_type            cmd_new, cmd_head;
   logic [CMD_W-1:0]   cmd_word;
   logic               cmd_push, cmd_full, cmd_pop, cmd_empty;
   rsp_type            rsp_new, rsp_head;
   logic [RSP_W-1:0]   rsp_word;
   logic               rsp_push, rsp_full;

   drs_front #(
      .MAX_TASKS (MAX_TASKS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_action      (req_action),
      .req_first_task  (req_first_task),
      .req_second_task (req_second_task),
      .req_count_value (req_count_value),
      .req_leaf_flag   (req_leaf_flag),
      .cmd_push        (cmd_push),
      .cmd_out         (cmd_new),
      .cmd_full        (cmd_full)
   );

   drs_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .wr_data (cmd_new),
      .full    (cmd_full),
      .pop     (cmd_pop),
      .rd_data (cmd_word),
      .empty   (cmd_empty)
   );

   assign cmd_head = cmd_word;

   drs_back #(
      .MAX_TASKS  (MAX_TASKS),
      .COUNT_BITS (COUNT_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_pop   (cmd_pop),
      .cmd_head  (cmd_head),
      .rsp_full  (rsp_full),
      .rsp_push  (rsp_push),
      .rsp_out   (rsp_new)
   );

   drs_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (rsp_push),
      .wr_data (rsp_new),
      .full    (rsp_full),
      .pop     (rsp_pop),
      .rd_data (rsp_word),
      .empty   (rsp_empty)
   );

   // Unpack the oldest result onto the ports.
   assign rsp_head         = rsp_word;
   assign rsp_task_index   = rsp_head.task_index;
   assign rsp_taken_amount = rsp_head.taken_amount;
   assign rsp_status       = rsp_head.status;
   assign rsp_last_flag    = rsp_head.last_flag;

endmodule
